>>> design/wbpf_pkg.sv
// Shared types, byte codes, patterns and helper functions of the binary product framer.
package wbpf_pkg;

	localparam int LENGTH_BITS = 24;
	localparam int LOOKAHEAD   = 4;
	localparam int HeldIdxW    = $clog2(LOOKAHEAD);
	localparam int HeldCntW    = $clog2(LOOKAHEAD + 1);
	localparam int OutLenW     = 24;
	localparam int WideW       = 33;

	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_ESC = 8'h1B;

	localparam logic [2:0] KIND_OUTSIDE = 3'd0;
	localparam logic [2:0] KIND_HEADER  = 3'd1;
	localparam logic [2:0] KIND_DATA    = 3'd2;
	localparam logic [2:0] KIND_ESCDROP = 3'd3;
	localparam logic [2:0] KIND_SENT    = 3'd4;
	localparam logic [2:0] KIND_SHORT   = 3'd5;

	localparam logic [15:0] MIN_LEN_RESET = 16'd32;

	localparam logic [7:0] PAT_HEAD  [LOOKAHEAD] = '{CH_SOH, CH_CR, CH_CR, CH_NL};
	localparam logic [7:0] PAT_TRAIL [LOOKAHEAD] = '{CH_CR, CH_CR, CH_NL, CH_ETX};
	localparam logic [7:0] PAT_NEXT  [LOOKAHEAD] = '{CH_NL, CH_SOH, CH_CR, CH_CR};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         event_byte;
		logic [2:0]         event_kind;
		logic [OutLenW-1:0] product_length;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic                 is_soh;
		logic                 is_cr;
		logic                 is_nl;
		logic                 is_etx;
		logic                 is_esc;
		logic [LOOKAHEAD-1:0] pat_ok;
	} byte_class_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        chunk_end;
		byte_class_t cls;
	} queue_item_t;

	// Decode the control codes and the per-position pattern matches of one byte
	function automatic byte_class_t classify(input logic [7:0] ch);
		byte_class_t c;
		begin
			c.is_soh = (ch == CH_SOH);
			c.is_cr  = (ch == CH_CR);
			c.is_nl  = (ch == CH_NL);
			c.is_etx = (ch == CH_ETX);
			c.is_esc = (ch == CH_ESC);
			for (int i = 0; i < LOOKAHEAD; i++) begin
				c.pat_ok[i] = (ch == PAT_HEAD[i]) || (ch == PAT_TRAIL[i]) ||
					(ch == PAT_NEXT[i]);
			end
			return c;
		end
	endfunction

	// Saturate a length count to the reported width
	function automatic logic [OutLenW-1:0] sat_out(input logic [LENGTH_BITS-1:0] len);
		logic [WideW-1:0] wide;
		begin
			wide = WideW'(len);
			if (wide > WideW'({OutLenW{1'b1}}))
				return {OutLenW{1'b1}};
			return OutLenW'(wide);
		end
	endfunction

endpackage

>>> design/wbpf_front.sv
// Input side: accepts requests, classifies each byte and queues it for the framer.
module wbpf_front
	import wbpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        q_valid,
	input  logic        q_ready,
	output queue_item_t q_item
);

	queue_item_t slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// Store classified request
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].data_byte <= in_item.data_byte;
			slot_q[wr_ptr_q].chunk_end <= in_item.chunk_end;
			slot_q[wr_ptr_q].cls       <= classify(in_item.data_byte);
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

>>> design/wbpf_back.sv
// Framer core: header/trailer state machine, lookahead hold, replay and result register.
module wbpf_back
	import wbpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        q_valid,
	output logic        q_ready,
	input  queue_item_t q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	typedef enum logic [3:0] {
		ST_START, ST_SEARCH, ST_SOH, ST_SOH_CR, ST_SOH_CR_CR,
		ST_BODY, ST_CR, ST_CR_CR, ST_CR_CR_NL, ST_HOLD
	} state_t;

	state_t                 state_q, state_d;
	logic [15:0]            min_len_q;
	logic [LENGTH_BITS-1:0] len_q, len_d, len_inc;
	logic [7:0]             held_q [LOOKAHEAD];
	logic [HeldCntW-1:0]    held_cnt_q, held_cnt_d, held_cnt_inc;
	logic [HeldIdxW-1:0]    held_idx;
	logic                   mis_q, mis_d, mis_new;
	logic                   rp_active_q, rp_active_d;
	logic [HeldIdxW-1:0]    rp_idx_q, rp_idx_d;
	logic [HeldIdxW-1:0]    rp_last_q, rp_last_d;
	logic                   out_valid_q;
	out_item_t              out_item_q;

	logic                   adv;
	logic                   go;
	logic                   hold_wr;
	logic [7:0]             ch;
	logic [7:0]             ev_byte;
	byte_class_t            cls;
	logic                   ce;
	logic                   may_hold;
	logic                   emit;
	logic [2:0]             kind;
	logic [OutLenW-1:0]     len_out;
	logic                   last_flag;
	logic                   ends_short;

	assign adv       = !out_valid_q || out_ready;
	assign go        = adv && (rp_active_q || q_valid);
	assign q_ready   = adv && !rp_active_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign held_idx     = held_cnt_q[HeldIdxW-1:0];
	assign held_cnt_inc = HeldCntW'(held_idx) + HeldCntW'(1);
	assign len_inc      = (&len_q) ? len_q : len_q + LENGTH_BITS'(1);
	assign ends_short   = WideW'(len_inc) < WideW'(min_len_q);

	// Select replayed byte or queued byte
	always_comb begin
		if (rp_active_q) begin
			ch       = held_q[rp_idx_q];
			cls      = classify(held_q[rp_idx_q]);
			ce       = 1'b0;
			may_hold = 1'b0;
		end else begin
			ch       = q_item.data_byte;
			cls      = q_item.cls;
			ce       = q_item.chunk_end;
			may_hold = 1'b1;
		end
	end

	// Framer next state and result
	always_comb begin
		state_d     = state_q;
		len_d       = len_q;
		held_cnt_d  = held_cnt_q;
		mis_d       = mis_q;
		rp_active_d = rp_active_q;
		rp_idx_d    = rp_idx_q;
		rp_last_d   = rp_last_q;
		emit        = 1'b1;
		ev_byte     = ch;
		kind        = KIND_OUTSIDE;
		len_out     = '0;
		last_flag   = 1'b1;
		hold_wr     = 1'b0;
		mis_new     = mis_q || !cls.pat_ok[held_idx];

		if (!rp_active_q && state_q == ST_HOLD) begin
			// Hold a lookahead byte; resolve the pending ETX when the window closes
			hold_wr    = 1'b1;
			held_cnt_d = held_cnt_inc;
			mis_d      = mis_new;
			if (held_cnt_inc == HeldCntW'(LOOKAHEAD) || ce) begin
				// the result refers to the pending ETX, not to the held byte
				ev_byte    = CH_ETX;
				len_d      = len_inc;
				kind       = KIND_DATA;
				state_d    = ST_BODY;
				if (held_cnt_inc != HeldCntW'(LOOKAHEAD) || !mis_new) begin
					kind    = ends_short ? KIND_SHORT : KIND_SENT;
					len_out = sat_out(len_inc);
					len_d   = '0;
					state_d = ST_START;
				end
				last_flag   = 1'b0;
				held_cnt_d  = '0;
				mis_d       = 1'b0;
				rp_active_d = 1'b1;
				rp_idx_d    = '0;
				rp_last_d   = held_idx;
			end else begin
				emit = 1'b0;
			end
		end else begin
			if (rp_active_q) begin
				rp_idx_d  = rp_idx_q + HeldIdxW'(1);
				last_flag = (rp_idx_q == rp_last_q);
				if (rp_idx_q == rp_last_q)
					rp_active_d = 1'b0;
			end
			unique case (state_q) inside
				ST_START, ST_SEARCH: begin
					state_d = cls.is_soh ? ST_SOH : ST_SEARCH;
				end
				ST_SOH: begin
					state_d = cls.is_cr ? ST_SOH_CR : ST_SEARCH;
				end
				ST_SOH_CR: begin
					state_d = cls.is_cr ? ST_SOH_CR_CR : ST_SEARCH;
				end
				ST_SOH_CR_CR: begin
					if (cls.is_nl) begin
						state_d = ST_BODY;
						len_d   = LENGTH_BITS'(4);
						kind    = KIND_HEADER;
					end else if (!cls.is_cr) begin
						state_d = ST_SEARCH;
					end
				end
				ST_BODY: begin
					if (cls.is_cr)
						state_d = ST_CR;
					len_d = len_inc;
					kind  = KIND_DATA;
				end
				ST_CR: begin
					state_d = cls.is_cr ? ST_CR_CR : ST_BODY;
					len_d   = len_inc;
					kind    = KIND_DATA;
				end
				ST_CR_CR: begin
					if (cls.is_nl)
						state_d = ST_CR_CR_NL;
					else if (!cls.is_cr)
						state_d = ST_BODY;
					len_d = len_inc;
					kind  = KIND_DATA;
				end
				ST_CR_CR_NL: begin
					if (cls.is_etx) begin
						if (!may_hold || ce) begin
							kind    = ends_short ? KIND_SHORT : KIND_SENT;
							len_out = sat_out(len_inc);
							len_d   = '0;
							state_d = ST_START;
						end else begin
							state_d    = ST_HOLD;
							held_cnt_d = '0;
							mis_d      = 1'b0;
							emit       = 1'b0;
						end
					end else if (cls.is_cr) begin
						state_d = ST_CR;
						len_d   = len_inc;
						kind    = KIND_DATA;
					end else if (cls.is_esc) begin
						state_d = ST_BODY;
						kind    = KIND_ESCDROP;
					end else begin
						state_d = ST_BODY;
						len_d   = len_inc;
						kind    = KIND_DATA;
					end
				end
				default: begin
					state_d = ST_START;
				end
			endcase
		end
	end

	// Write held lookahead bytes
	always_ff @(posedge clk) begin
		if (go && hold_wr)
			held_q[held_idx] <= ch;
	end

	// Hold framer state, configuration and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_START;
			min_len_q   <= MIN_LEN_RESET;
			len_q       <= '0;
			held_cnt_q  <= '0;
			mis_q       <= 1'b0;
			rp_active_q <= 1'b0;
			rp_idx_q    <= '0;
			rp_last_q   <= '0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			if (cfg_we)
				min_len_q <= cfg_wdata;
			if (go) begin
				state_q     <= state_d;
				len_q       <= len_d;
				held_cnt_q  <= held_cnt_d;
				mis_q       <= mis_d;
				rp_active_q <= rp_active_d;
				rp_idx_q    <= rp_idx_d;
				rp_last_q   <= rp_last_d;
			end
			if (go && emit) begin
				out_item_q.event_byte     <= ev_byte;
				out_item_q.event_kind     <= kind;
				out_item_q.product_length <= len_out;
				out_item_q.last           <= last_flag;
			end
			if (adv)
				out_valid_q <= go && emit;
		end
	end

endmodule

>>> design/wmo_binary_product_framer.sv
// Top level of the binary product framer: input queue front end and framer back end.
//
// Usage:
//   in_valid/in_ready/in_item carry one feed byte per request, with chunk_end set
//   when no further byte is available right now. out_valid/out_ready/out_item
//   carry result requests: byte, kind, product length on end kinds, and last on
//   the final result of a request. cfg_we/cfg_wdata write the minimum product
//   length; write it only while the block is idle.
// Path: an accepted request passes the 2-entry queue, then the result register.
// Throughput: one request per cycle while no stall or replay holds it. A byte after
//   a trailer ETX is held and gives no result; when the lookahead window closes,
//   the ETX result and then the replay of the held bytes follow, bounded by the
//   single result register loaded per cycle. No queued request is taken during the
//   replay; the 2-entry queue takes the first ones and in_ready drops once full.
// Reset: queue empties, framer returns to its search state, length count clears
//   and the minimum length returns to 32.
// Stall: while out_ready is low with a result waiting, the result register holds,
//   the framer stops, and in_ready drops once the queue is full.
module wmo_binary_product_framer
	import wbpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	logic        q_valid;
	logic        q_ready;
	queue_item_t q_item;

	wbpf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	wbpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> test/wmo_binary_product_framer_check.sv
// Checker for the binary product framer: predicts result requests and compares them.
`timescale 1ns / 100ps

module wmo_binary_product_framer_check
	import wbpf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_item,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_item,
	output int        fail_count,
	output int        pending_count
);

	typedef enum logic [3:0] {
		FR_START, FR_SEARCH, FR_SOH, FR_SOH_CR, FR_SOH_CR_CR,
		FR_BODY, FR_CR, FR_CR_CR, FR_CR_CR_NL, FR_HOLD
	} frame_state_t;

	frame_state_t           frame_state;
	logic [7:0]             lookahead_buf [LOOKAHEAD];
	int unsigned            lookahead_n;
	bit                     lookahead_bad;
	logic [LENGTH_BITS-1:0] byte_count;
	logic [15:0]            min_length;

	out_item_t step_events [$];
	out_item_t expected_events [$];

	// Queue one predicted event of the current request
	function automatic void note_event(input logic [7:0] b, input logic [2:0] kind,
		input logic [LENGTH_BITS-1:0] len);
		out_item_t ev;
		ev.event_byte     = b;
		ev.event_kind     = kind;
		// count width equals the reported width, so no clamp is needed here
		ev.product_length = OutLenW'(len);
		ev.last           = 1'b0;
		step_events.push_back(ev);
	endfunction

	// Advance the product length, holding at all ones
	function automatic void count_byte();
		if (byte_count != {LENGTH_BITS{1'b1}})
			byte_count = byte_count + LENGTH_BITS'(1);
	endfunction

	// Resolve a trailer ETX: end the product or keep the ETX as data
	function automatic void close_trailer(input bit ends);
		count_byte();
		if (ends) begin
			note_event(CH_ETX, (byte_count >= min_length) ? KIND_SENT : KIND_SHORT,
				byte_count);
			byte_count  = '0;
			frame_state = FR_START;
		end else begin
			note_event(CH_ETX, KIND_DATA, '0);
			frame_state = FR_BODY;
		end
	endfunction

	// Run one byte through the framing state machine
	function automatic void frame_byte(input logic [7:0] ch, input bit may_hold,
		input bit ce);
		bit body_byte;
		body_byte = 1'b0;
		unique case (frame_state) inside
			FR_START, FR_SEARCH: begin
				frame_state = (ch == CH_SOH) ? FR_SOH : FR_SEARCH;
				note_event(ch, KIND_OUTSIDE, '0);
			end
			FR_SOH: begin
				frame_state = (ch == CH_CR) ? FR_SOH_CR : FR_SEARCH;
				note_event(ch, KIND_OUTSIDE, '0);
			end
			FR_SOH_CR: begin
				frame_state = (ch == CH_CR) ? FR_SOH_CR_CR : FR_SEARCH;
				note_event(ch, KIND_OUTSIDE, '0);
			end
			FR_SOH_CR_CR: begin
				if (ch == CH_NL) begin
					// header done: length restarts at the four header bytes
					frame_state = FR_BODY;
					byte_count  = LENGTH_BITS'(4);
					note_event(ch, KIND_HEADER, '0);
				end else begin
					if (ch != CH_CR)
						frame_state = FR_SEARCH;
					note_event(ch, KIND_OUTSIDE, '0);
				end
			end
			FR_BODY: begin
				if (ch == CH_CR)
					frame_state = FR_CR;
				body_byte = 1'b1;
			end
			FR_CR: begin
				frame_state = (ch == CH_CR) ? FR_CR_CR : FR_BODY;
				body_byte = 1'b1;
			end
			FR_CR_CR: begin
				if (ch == CH_NL)
					frame_state = FR_CR_CR_NL;
				else if (ch != CH_CR)
					frame_state = FR_BODY;
				body_byte = 1'b1;
			end
			FR_CR_CR_NL: begin
				if (ch == CH_ETX) begin
					// nothing can be held at chunk end or during replay
					if (!may_hold || ce)
						close_trailer(1'b1);
					else begin
						frame_state   = FR_HOLD;
						lookahead_n   = 0;
						lookahead_bad = 1'b0;
					end
				end else if (ch == CH_CR) begin
					frame_state = FR_CR;
					body_byte   = 1'b1;
				end else begin
					frame_state = FR_BODY;
					if (ch == CH_ESC)
						note_event(ch, KIND_ESCDROP, '0);
					else
						body_byte = 1'b1;
				end
			end
			default: begin
				frame_state = FR_START;
				note_event(ch, KIND_OUTSIDE, '0);
			end
		endcase
		if (body_byte) begin
			count_byte();
			note_event(ch, KIND_DATA, '0);
		end
	endfunction

	// Predict every event of one accepted request and append them to the expectations
	function automatic void predict_events(input logic [7:0] ch, input bit ce);
		int unsigned pos;
		bit ends;
		bit resolved;
		step_events.delete();
		if (frame_state == FR_HOLD) begin
			pos = lookahead_n % LOOKAHEAD;
			lookahead_buf[pos] = ch;
			if (ch != PAT_TRAIL[pos] && ch != PAT_HEAD[pos] && ch != PAT_NEXT[pos])
				lookahead_bad = 1'b1;
			lookahead_n = pos + 1;
			resolved = 1'b1;
			ends     = 1'b0;
			if (lookahead_n >= LOOKAHEAD)
				ends = !lookahead_bad;
			else if (ce)
				ends = 1'b1;
			else
				resolved = 1'b0;
			// close the window, then replay the held bytes
			if (resolved) begin
				close_trailer(ends);
				for (int k = 0; k < lookahead_n; k++)
					frame_byte(lookahead_buf[k], 1'b0, 1'b0);
				lookahead_n   = 0;
				lookahead_bad = 1'b0;
			end
		end else begin
			frame_byte(ch, 1'b1, ce);
		end
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last = 1'b1;
		foreach (step_events[i])
			expected_events.push_back(step_events[i]);
	endfunction

	// Compare results, track the register, and predict each accepted request
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			frame_state   = FR_START;
			lookahead_n   = 0;
			lookahead_bad = 1'b0;
			byte_count    = '0;
			min_length    = MIN_LEN_RESET;
			expected_events.delete();
			fail_count    = 0;
			pending_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					fail_count++;
					$display("%0t: result with none expected: byte=%h kind=%0d length=%0d last=%b",
						$time, out_item.event_byte, out_item.event_kind,
						out_item.product_length, out_item.last);
				end else begin
					want = expected_events.pop_front();
					if (out_item.event_byte !== want.event_byte ||
						out_item.event_kind !== want.event_kind ||
						out_item.product_length !== want.product_length ||
						out_item.last !== want.last) begin
						fail_count++;
						$display("%0t: expected byte=%h kind=%0d length=%0d last=%b, got byte=%h kind=%0d length=%0d last=%b",
							$time, want.event_byte, want.event_kind,
							want.product_length, want.last, out_item.event_byte,
							out_item.event_kind, out_item.product_length, out_item.last);
					end
				end
			end
			if (cfg_we)
				min_length = cfg_wdata;
			if (in_valid && in_ready)
				predict_events(in_item.data_byte, in_item.chunk_end);
			pending_count = expected_events.size();
		end
	end

endmodule

>>> test/wmo_binary_product_framer_test.sv
// Testbench top for the binary product framer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module wmo_binary_product_framer_test
	import wbpf_pkg::*;
;

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 56;
	localparam int STALL_PHASE  = 3;
	localparam int LONG_STALL   = 400;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_GAP      = 13;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	in_item_t    in_item   = '0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	out_item_t   out_item;
	int          fail_count;
	int          pending_count;

	bit          tx_calm   = 1'b0;
	bit          rx_calm   = 1'b0;
	bit          stall_req = 1'b0;
	int          sent      = 0;
	int          cycle_count = 0;
	in_item_t    burst [$];

	wmo_binary_product_framer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	wmo_binary_product_framer_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_item       (in_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_item      (out_item),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// Run the clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("wmo_binary_product_framer: mismatch");
			$finish;
		end
	end

	// Accept result requests with random stalls and one long hold-off
	initial begin : result_sink
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (stall_req) begin
				out_ready <= 1'b0;
				stall_req = 1'b0;
				repeat (LONG_STALL) @(negedge clk);
			end
			gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	function automatic void put_byte(input logic [7:0] b, input bit ce);
		in_item_t item;
		item.data_byte = b;
		item.chunk_end = ce;
		burst.push_back(item);
	endfunction

	// Pick a body byte, biased toward the control codes
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		case ($urandom_range(0, 11))
			0, 1:    b = CH_CR;
			2:       b = CH_NL;
			3:       b = CH_ESC;
			4:       b = CH_ETX;
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	// Offer one request after a random gap and hold it until accepted
	task automatic send_item(input in_item_t item);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item  <= item;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_burst();
		foreach (burst[i])
			send_item(burst[i]);
		burst.delete();
	endtask

	// Build one product with random content, a follow-up and sometimes a broken byte
	task automatic send_product();
		int body_n;
		int n;
		int idx;
		tx_calm = ($urandom_range(0, 4) == 0);
		rx_calm = ($urandom_range(0, 4) == 0);
		repeat ($urandom_range(0, 2))
			put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
		put_byte(CH_SOH, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_CR, 1'b0);
		repeat ($urandom_range(0, 2))
			put_byte(CH_CR, 1'b0);
		put_byte(CH_NL, 1'b0);
		body_n = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 60) : $urandom_range(0, 16);
		repeat (body_n)
			put_byte(body_byte(), $urandom_range(0, 23) == 0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_NL, 1'b0);
		if ($urandom_range(0, 3) == 0)
			put_byte(CH_ESC, 1'b0);
		put_byte(CH_ETX, $urandom_range(0, 5) == 0);
		// follow the trailer with bytes that do or do not fit the lookahead patterns
		case ($urandom_range(0, 5))
			1: put_byte(CH_NL, 1'b0);
			2: repeat ($urandom_range(1, 4))
				put_byte(8'($urandom_range(0, 255)), 1'b0);
			3: begin
				n = $urandom_range(1, 3);
				for (int k = 0; k < n; k++)
					put_byte(PAT_HEAD[k], k == n - 1);
			end
			4: for (int k = 0; k < LOOKAHEAD; k++)
				put_byte(PAT_TRAIL[k], 1'b0);
			5: begin
				for (int k = 0; k < LOOKAHEAD - 1; k++)
					put_byte(PAT_HEAD[k], 1'b0);
				put_byte(8'h41, 1'b0);
			end
			default: ;
		endcase
		if ($urandom_range(0, 4) == 0) begin
			idx = $urandom_range(0, burst.size() - 1);
			burst[idx].data_byte = 8'($urandom_range(0, 255));
		end
		send_burst();
	endtask

	// Drop valid and wait until every result is out and the pipeline is quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_min_length(input logic [15:0] value);
		drain();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [15:0] phase_min_length(input int ph);
		logic [15:0] v;
		case (ph)
			1:       v = 16'h0000;
			2:       v = 16'hFFFF;
			5:       v = 16'd1;
			default: v = 16'($urandom_range(8, 40));
		endcase
		return v;
	endfunction

	// Reset, directed requests, then random products over several length settings
	initial begin : stimulus
		int phase_start;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// header with an extra CR, extreme bytes, escape and ETX at chunk end
		put_byte(CH_SOH, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_NL, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_NL, 1'b0);
		put_byte(CH_ESC, 1'b0);
		put_byte(CH_ETX, 1'b1);
		// lookahead that does not fit: ETX stays data, held bytes replay
		put_byte(CH_SOH, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_NL, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_NL, 1'b0);
		put_byte(CH_ETX, 1'b0);
		put_byte(8'h55, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_NL, 1'b0);
		put_byte(8'h20, 1'b0);
		// lookahead cut short by chunk end
		put_byte(CH_CR, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_NL, 1'b0);
		put_byte(CH_ETX, 1'b0);
		put_byte(CH_SOH, 1'b1);
		send_burst();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0)
				write_min_length(phase_min_length(ph));
			if (ph == STALL_PHASE)
				stall_req = 1'b1;
			phase_start = sent;
			while (sent - phase_start < PHASE_ITEMS)
				send_product();
		end

		drain();
		if (fail_count == 0 && pending_count == 0)
			$display("wmo_binary_product_framer: match");
		else
			$display("wmo_binary_product_framer: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
design/wbpf_pkg.sv
design/wbpf_front.sv
design/wbpf_back.sv
design/wmo_binary_product_framer.sv
test/wmo_binary_product_framer_check.sv
test/wmo_binary_product_framer_test.sv
